// File: rtl/core/msrs_pkg.sv
// Package for the multiplexed segment row scanner.
// Holds shared types, command codes and small helper functions.
// No dependencies.
package msrs_pkg;

    localparam int ROW_COUNT = 7;
    localparam logic [2:0] LAST_INDEX = 3'd4;
    localparam logic [2:0] LAST_ROW = 3'd7;
    localparam logic [6:0] MAX_HOURS = 7'd99;
    localparam logic [5:0] MAX_MINUTES = 6'd59;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] REG_CODES_LOW = 2'd0;
    localparam logic [1:0] REG_CODES_HIGH = 2'd1;
    localparam logic [1:0] REG_COMMON_ANODE = 2'd2;
    localparam logic [1:0] REG_INVERT = 2'd3;

    localparam logic [2:0] IDX_MIN_TENS = 3'd0;
    localparam logic [2:0] IDX_MIN_UNITS = 3'd1;
    localparam logic [2:0] IDX_ROW_CODE = 3'd2;
    localparam logic [2:0] IDX_HOUR_TENS = 3'd3;
    localparam logic [2:0] IDX_HOUR_UNITS = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    typedef struct packed {
        logic [3:0] hour_tens;
        logic [3:0] hour_units;
        logic [2:0] min_tens;
        logic [3:0] min_units;
        logic       colon;
    } entry_t;

    typedef struct packed {
        logic take;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic tick_hit;
        logic out_free;
        logic last_idx;
    } ctrl_status_t;

    // Quotient by ten for values up to 127, by reciprocal multiplication.
    function automatic logic [3:0] div10(input logic [6:0] v);
        logic [14:0] p;
        p = {8'd0, v} * 15'd205;
        return p[14:11];
    endfunction

    // Bit of the row code that selects the given display row.
    function automatic logic [2:0] row_bit(input logic [2:0] row);
        logic [2:0] b;
        unique case (row)
            3'd1: b = 3'd5;
            3'd2: b = 3'd4;
            3'd3: b = 3'd3;
            3'd4: b = 3'd2;
            3'd5: b = 3'd1;
            3'd6: b = 3'd0;
            3'd7: b = 3'd6;
            default: b = 3'd5;
        endcase
        return b;
    endfunction

    // Mirrors bits 0 to 6 and keeps bit 7.
    function automatic logic [7:0] reverse_low7(input logic [7:0] c);
        logic [7:0] r;
        r[7] = c[7];
        for (int k = 0; k < 7; k++) begin
            r[6 - k] = c[k];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/multiplexed_segment_row_scanner.sv
// Top level of the multiplexed segment row scanner.
// Joins msrs_ctrl and msrs_datapath; uses msrs_pkg.
//
// The input channel takes commands: write a row, clear a row, or scan tick.
// A write or clear gives no output item. A tick advances the scan row
// through 1 to 7; if that row is active the block emits five output items,
// one per cycle when the receiver is ready: minute tens, minute units,
// row code with colon, hour tens and hour units. The fifth item carries
// tlast. An emitting tick occupies the input from its accepting cycle
// until the last byte is loaded into the single output register; the
// first byte is presented after the controller enters its emit state and
// loads it into the output register. s_tready is low while the bytes of a
// tick are being sent; a new command is taken while the last byte still
// waits in the output register. When the receiver stalls the output item
// holds and the sequence pauses. Reset clears all rows to inactive, sets
// the scan row before row one and restores the register defaults.
// Configuration is written through cfg_we, cfg_addr and cfg_wdata and
// should change only while the block is idle.
module multiplexed_segment_row_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [63:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: row_number[2:0], upper_value[9:3], lower_value[15:10],
    // colon_on[16], zero fill.
    input  logic [23:0] s_tdata,
    // Fields from bit 0: opcode[1:0].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: chain_byte[7:0], chip_index[10:8], zero fill.
    output logic [15:0] m_tdata,
    output logic        m_tlast
);

    msrs_pkg::ctrl_cmd_t    cmd;
    msrs_pkg::ctrl_status_t status;

    msrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    msrs_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

    a_last_at_fifth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[10:8] == msrs_pkg::LAST_INDEX)
        else $error("tlast on a byte other than the fifth");

    a_next_byte_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tdata[10:8] == 3'($past(m_tdata[10:8]) + 3'd1)))
        else $error("chain byte sequence broken");

    a_no_input_while_emitting: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !s_tready)
        else $error("input accepted while bytes are being sent");

endmodule

// File: rtl/core/msrs_ctrl.sv
// Controller for the multiplexed segment row scanner.
// Sequences input acceptance and the five-byte emit; uses msrs_pkg.
module msrs_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  msrs_pkg::ctrl_status_t status,
    output msrs_pkg::ctrl_cmd_t    cmd
);

    msrs_pkg::state_t state_reg, state_next;

    always_comb begin
        s_tready = (state_reg == msrs_pkg::ST_IDLE);
        cmd.take = s_tready && s_tvalid;
        cmd.load = (state_reg == msrs_pkg::ST_EMIT) && status.out_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            msrs_pkg::ST_IDLE: begin
                if (cmd.take && status.tick_hit) begin
                    state_next = msrs_pkg::ST_EMIT;
                end
            end
            msrs_pkg::ST_EMIT: begin
                if (cmd.load && status.last_idx) begin
                    state_next = msrs_pkg::ST_IDLE;
                end
            end
            default: state_next = msrs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= msrs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/msrs_datapath.sv
// Datapath for the multiplexed segment row scanner.
// Holds configuration, the row store, the scan row and the output register; uses msrs_pkg.
module msrs_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_addr,
    input  logic [63:0]            cfg_wdata,
    input  logic [1:0]             s_tuser,
    input  logic [23:0]            s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata,
    output logic                   m_tlast,
    input  msrs_pkg::ctrl_cmd_t    cmd,
    output msrs_pkg::ctrl_status_t status
);

    logic [63:0] codes_low_reg;
    logic [15:0] codes_high_reg;
    logic        anode_reg;
    logic        invert_reg;

    msrs_pkg::entry_t row_store_reg [msrs_pkg::ROW_COUNT];
    logic [msrs_pkg::ROW_COUNT-1:0] active_reg;
    logic [2:0] scan_row_reg, scan_row_next;
    logic [2:0] idx_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic [2:0] out_idx_reg;
    logic       out_last_reg;

    logic [1:0] opcode;
    logic [2:0] row_num;
    logic [6:0] hv;
    logic [5:0] mv;
    logic       colon_in;
    logic [2:0] wr_idx;
    logic [2:0] rd_idx;
    logic [2:0] next_idx;
    logic [3:0] h_tens, m_tens;
    logic [6:0] h_units_w, m_units_w;
    msrs_pkg::entry_t new_entry;
    msrs_pkg::entry_t cur;
    logic [79:0] codes;
    logic [3:0] digit;
    logic       flip;
    logic       is_row;
    logic [7:0] code;
    logic [7:0] digit_byte;
    logic [7:0] row_byte;
    logic [7:0] chain_byte;

    always_comb begin
        opcode = s_tuser;
        row_num = s_tdata[2:0];
        hv = (s_tdata[9:3] > msrs_pkg::MAX_HOURS) ? 7'd0 : s_tdata[9:3];
        mv = (s_tdata[15:10] > msrs_pkg::MAX_MINUTES) ? 6'd0 : s_tdata[15:10];
        colon_in = s_tdata[16];
        wr_idx = 3'(row_num - 3'd1);

        h_tens = msrs_pkg::div10(hv);
        m_tens = msrs_pkg::div10({1'b0, mv});
        h_units_w = 7'(hv - 7'({3'd0, h_tens} * 7'd10));
        m_units_w = 7'({1'b0, mv} - 7'({3'd0, m_tens} * 7'd10));
        new_entry.hour_tens = h_tens;
        new_entry.hour_units = h_units_w[3:0];
        new_entry.min_tens = m_tens[2:0];
        new_entry.min_units = m_units_w[3:0];
        new_entry.colon = colon_in;

        if ((scan_row_reg == msrs_pkg::LAST_ROW) || (scan_row_reg == 3'd0)) begin
            scan_row_next = 3'd1;
        end else begin
            scan_row_next = 3'(scan_row_reg + 3'd1);
        end
        next_idx = 3'(scan_row_next - 3'd1);
        rd_idx = 3'(scan_row_reg - 3'd1);

        status.tick_hit = (opcode == msrs_pkg::OP_TICK) && active_reg[next_idx];
        status.out_free = !out_valid_reg || m_tready;
        status.last_idx = (idx_reg == msrs_pkg::LAST_INDEX);
    end

    always_comb begin
        cur = row_store_reg[rd_idx];
        codes = {codes_high_reg, codes_low_reg};
        digit = 4'd0;
        flip = 1'b0;
        is_row = 1'b0;
        case (idx_reg)
            msrs_pkg::IDX_MIN_TENS: digit = {1'b0, cur.min_tens};
            msrs_pkg::IDX_MIN_UNITS: digit = cur.min_units;
            msrs_pkg::IDX_ROW_CODE: is_row = 1'b1;
            msrs_pkg::IDX_HOUR_TENS: begin
                digit = cur.hour_tens;
                flip = (scan_row_reg >= 3'd2);
            end
            msrs_pkg::IDX_HOUR_UNITS: begin
                digit = cur.hour_units;
                flip = (scan_row_reg >= 3'd2) && (scan_row_reg != 3'd3);
            end
            default: digit = 4'd0;
        endcase
        code = codes[{digit, 3'b000} +: 8];
        code[7] = anode_reg;
        digit_byte = flip ? msrs_pkg::reverse_low7(code) : code;
        row_byte = ~(8'd1 << msrs_pkg::row_bit(scan_row_reg));
        if (cur.colon) begin
            row_byte[7] = 1'b0;
        end
        if (!anode_reg) begin
            row_byte = ~row_byte;
        end
        chain_byte = is_row ? row_byte : digit_byte;
        if (invert_reg) begin
            chain_byte = ~chain_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codes_low_reg <= 64'd0;
            codes_high_reg <= 16'd0;
            anode_reg <= 1'b1;
            invert_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                msrs_pkg::REG_CODES_LOW: codes_low_reg <= cfg_wdata;
                msrs_pkg::REG_CODES_HIGH: codes_high_reg <= cfg_wdata[15:0];
                msrs_pkg::REG_COMMON_ANODE: anode_reg <= cfg_wdata[0];
                msrs_pkg::REG_INVERT: invert_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take && (opcode == msrs_pkg::OP_WRITE) && (row_num != 3'd0)) begin
            row_store_reg[wr_idx] <= new_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
            scan_row_reg <= 3'd0;
            idx_reg <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.take && (row_num != 3'd0)) begin
                if (opcode == msrs_pkg::OP_WRITE) begin
                    active_reg[wr_idx] <= 1'b1;
                end else if (opcode == msrs_pkg::OP_CLEAR) begin
                    active_reg[wr_idx] <= 1'b0;
                end
            end
            if (cmd.take && (opcode == msrs_pkg::OP_TICK)) begin
                scan_row_reg <= scan_row_next;
                idx_reg <= 3'd0;
            end else if (cmd.load) begin
                idx_reg <= 3'(idx_reg + 3'd1);
            end
            if (cmd.load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_byte_reg <= chain_byte;
            out_idx_reg <= idx_reg;
            out_last_reg <= status.last_idx;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {5'd0, out_idx_reg, out_byte_reg};
    assign m_tlast = out_last_reg;

endmodule

// File: tb/tb_multiplexed_segment_row_scanner.sv
// Self-checking testbench for multiplexed_segment_row_scanner.
// Predicts the chain bytes of every scan tick and compares each output item.
// Depends on msrs_pkg and the scanner RTL.
`timescale 1ns / 100ps

module tb_multiplexed_segment_row_scanner;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 12;

    typedef struct {
        logic [7:0] chain_byte;
        logic [2:0] chip_index;
        logic       last_byte;
    } chain_item_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [63:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;

    multiplexed_segment_row_scanner u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Shadow copy of the display rows and settings.
    logic [3:0]  sh_hour_tens [1:7];
    logic [3:0]  sh_hour_units [1:7];
    logic [3:0]  sh_min_tens [1:7];
    logic [3:0]  sh_min_units [1:7];
    logic        sh_colon [1:7];
    logic        sh_active [1:7];
    logic [2:0]  sh_scan_row;
    logic [63:0] sh_codes_low;
    logic [15:0] sh_codes_high;
    logic        sh_anode;
    logic        sh_invert;

    chain_item_t chain_q[$];
    int          mismatches;
    int          quiet_cycles;
    int          ready_hold;
    bit          send_idle_on;
    bit          ready_idle_on;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [7:0] segment_code(input logic [3:0] d);
        if (d < 4'd8) begin
            return sh_codes_low[8 * d +: 8];
        end else if (d < 4'd10) begin
            return sh_codes_high[8 * (d - 4'd8) +: 8];
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] digit_pattern(input logic [3:0] d, input bit flip);
        logic [7:0] c;
        logic [7:0] m;
        c = segment_code(d);
        c[7] = sh_anode;
        m = c;
        if (flip) begin
            for (int k = 0; k < 7; k++) begin
                m[6 - k] = c[k];
            end
        end
        return m;
    endfunction

    function automatic logic [7:0] select_pattern(input logic [2:0] row, input logic colon);
        logic [7:0] m;
        int         pos;
        case (row)
            3'd1: pos = 5;
            3'd2: pos = 4;
            3'd3: pos = 3;
            3'd4: pos = 2;
            3'd5: pos = 1;
            3'd6: pos = 0;
            default: pos = 6;
        endcase
        m = 8'hFF;
        m[pos] = 1'b0;
        if (colon) begin
            m[7] = 1'b0;
        end
        return sh_anode ? m : ~m;
    endfunction

    task automatic apply_command(input logic [1:0] op, input logic [2:0] row,
                                 input logic [6:0] hours, input logic [5:0] minutes,
                                 input logic colon);
        logic [6:0]  hv;
        logic [5:0]  mv;
        logic [7:0]  bytes [5];
        logic [2:0]  r;
        chain_item_t it;
        hv = (hours > msrs_pkg::MAX_HOURS) ? 7'd0 : hours;
        mv = (minutes > msrs_pkg::MAX_MINUTES) ? 6'd0 : minutes;
        if (op == msrs_pkg::OP_WRITE && row != 3'd0) begin
            sh_hour_tens[row] = 4'(hv / 7'd10);
            sh_hour_units[row] = 4'(hv % 7'd10);
            sh_min_tens[row] = 4'(mv / 6'd10);
            sh_min_units[row] = 4'(mv % 6'd10);
            sh_colon[row] = colon;
            sh_active[row] = 1'b1;
        end else if (op == msrs_pkg::OP_CLEAR && row != 3'd0) begin
            sh_active[row] = 1'b0;
        end else if (op == msrs_pkg::OP_TICK) begin
            sh_scan_row = (sh_scan_row >= msrs_pkg::LAST_ROW) ? 3'd1 : sh_scan_row + 3'd1;
            r = sh_scan_row;
            if (sh_active[r]) begin
                bytes[msrs_pkg::IDX_MIN_TENS] = digit_pattern(sh_min_tens[r], 1'b0);
                bytes[msrs_pkg::IDX_MIN_UNITS] = digit_pattern(sh_min_units[r], 1'b0);
                bytes[msrs_pkg::IDX_ROW_CODE] = select_pattern(r, sh_colon[r]);
                bytes[msrs_pkg::IDX_HOUR_TENS] = digit_pattern(sh_hour_tens[r], r >= 3'd2);
                bytes[msrs_pkg::IDX_HOUR_UNITS] = digit_pattern(sh_hour_units[r],
                                                                r >= 3'd2 && r != 3'd3);
                for (int k = 0; k < 5; k++) begin
                    it.chain_byte = sh_invert ? ~bytes[k] : bytes[k];
                    it.chip_index = k[2:0];
                    it.last_byte = (k[2:0] == msrs_pkg::LAST_INDEX);
                    chain_q.push_back(it);
                end
            end
        end
    endtask

    task automatic send_command(input logic [1:0] op, input logic [2:0] row,
                                input logic [6:0] hours, input logic [5:0] minutes,
                                input logic colon);
        if (send_idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end else begin
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {7'd0, colon, minutes, hours, row};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        apply_command(op, row, hours, minutes, colon);
    endtask

    task automatic send_random_command();
        int         pick;
        logic [1:0] op;
        logic [2:0] row;
        logic [6:0] hours;
        logic [5:0] minutes;
        pick = $urandom_range(0, 99);
        row = 3'($urandom_range(1, 7));
        hours = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                            : 7'($urandom_range(0, 99));
        minutes = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(0, 59));
        if (pick < 35) begin
            op = msrs_pkg::OP_WRITE;
        end else if (pick < 45) begin
            op = msrs_pkg::OP_CLEAR;
        end else if (pick < 88) begin
            op = msrs_pkg::OP_TICK;
        end else begin
            op = ($urandom_range(0, 1) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
            row = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(0, 7));
        end
        send_command(op, row, hours, minutes, 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (chain_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        case (idx)
            msrs_pkg::REG_CODES_LOW: sh_codes_low = value;
            msrs_pkg::REG_CODES_HIGH: sh_codes_high = value[15:0];
            msrs_pkg::REG_COMMON_ANODE: sh_anode = value[0];
            msrs_pkg::REG_INVERT: sh_invert = value[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [63:0] low, input logic [15:0] high,
                             input logic anode, input logic invert);
        wait_idle();
        write_register(msrs_pkg::REG_CODES_LOW, low);
        write_register(msrs_pkg::REG_CODES_HIGH, {48'd0, high});
        write_register(msrs_pkg::REG_COMMON_ANODE, {63'd0, anode});
        write_register(msrs_pkg::REG_INVERT, {63'd0, invert});
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_directed();
        configure(64'h077D6D664F5B063F, 16'h6F7F, 1'b1, 1'b0);
        send_command(msrs_pkg::OP_WRITE, 3'd1, 7'd99, 6'd59, 1'b1);
        send_command(msrs_pkg::OP_WRITE, 3'd2, 7'd0, 6'd0, 1'b0);
        send_command(msrs_pkg::OP_WRITE, 3'd3, 7'd127, 6'd63, 1'b1);
        send_command(msrs_pkg::OP_WRITE, 3'd4, 7'd100, 6'd60, 1'b0);
        send_command(msrs_pkg::OP_WRITE, 3'd5, 7'd45, 6'd12, 1'b1);
        send_command(msrs_pkg::OP_WRITE, 3'd6, 7'd9, 6'd5, 1'b0);
        send_command(msrs_pkg::OP_WRITE, 3'd7, 7'd88, 6'd37, 1'b1);
        send_command(msrs_pkg::OP_WRITE, 3'd0, 7'd12, 6'd34, 1'b1);
        send_command(OP_UNUSED, 3'd5, 7'd127, 6'd63, 1'b1);
        repeat (7) send_command(msrs_pkg::OP_TICK, 3'd0, 7'd0, 6'd0, 1'b0);
        send_command(msrs_pkg::OP_CLEAR, 3'd2, 7'd0, 6'd0, 1'b0);
        send_command(msrs_pkg::OP_CLEAR, 3'd0, 7'd127, 6'd63, 1'b1);
        repeat (7) send_command(msrs_pkg::OP_TICK, 3'd7, 7'd127, 6'd63, 1'b1);
    endtask

    task automatic test_register_extremes();
        configure(64'd0, 16'd0, 1'b1, 1'b0);
        repeat (20) send_random_command();
        configure({64{1'b1}}, 16'hFFFF, 1'b0, 1'b1);
        repeat (20) send_random_command();
        configure({$urandom, $urandom}, 16'($urandom), 1'b0, 1'b0);
        repeat (20) send_random_command();
        configure({$urandom, $urandom}, 16'($urandom), 1'b1, 1'b1);
        repeat (20) send_random_command();
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < 320; n++) begin
            if (n % 80 == 0) begin
                configure({$urandom, $urandom}, 16'($urandom), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
            if (n == 150) begin
                wait_idle();
            end
            send_random_command();
        end
    endtask

    task automatic test_back_to_back();
        send_idle_on = 1'b0;
        ready_idle_on = 1'b0;
        repeat (60) send_random_command();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_tready <= 1'b0;
        end else if (ready_idle_on && $urandom_range(0, 4) == 0) begin
            ready_hold <= $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        chain_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (chain_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected item: byte %h index %0d last %b",
                             m_tdata[7:0], m_tdata[10:8], m_tlast);
                end
            end else begin
                want = chain_q.pop_front();
                if (m_tdata[7:0] !== want.chain_byte || m_tdata[10:8] !== want.chip_index ||
                    m_tlast !== want.last_byte || m_tdata[15:11] !== 5'd0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch: expected byte %h index %0d last %b, got %h %0d %b",
                                 want.chain_byte, want.chip_index, want.last_byte,
                                 m_tdata[7:0], m_tdata[10:8], m_tlast);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("** multiplexed_segment_row_scanner: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = 2'd0;
        cfg_wdata = 64'd0;
        s_tvalid = 1'b0;
        s_tdata = 24'd0;
        s_tuser = 2'd0;
        m_tready = 1'b0;
        ready_hold = 0;
        quiet_cycles = 0;
        mismatches = 0;
        send_idle_on = 1'b1;
        ready_idle_on = 1'b1;
        for (int r = 1; r <= 7; r++) begin
            sh_hour_tens[r] = 4'd0;
            sh_hour_units[r] = 4'd0;
            sh_min_tens[r] = 4'd0;
            sh_min_units[r] = 4'd0;
            sh_colon[r] = 1'b0;
            sh_active[r] = 1'b0;
        end
        sh_scan_row = 3'd0;
        sh_codes_low = 64'd0;
        sh_codes_high = 16'd0;
        sh_anode = 1'b1;
        sh_invert = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_register_extremes();
        test_random_traffic();
        test_back_to_back();

        while (chain_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("** multiplexed_segment_row_scanner: PASSED **");
        end else begin
            $display("** multiplexed_segment_row_scanner: FAILED **");
        end
        $finish;
    end

endmodule
